/* rtl/sbsd_pkg.sv */
// Shared types and constants for the SHA-1 block seed derivation engine.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none

package sbsd_pkg;

	// Queue between the word front end and the compression back end
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Words per block and rounds per block
	localparam logic [3:0] WORD_LAST  = 4'd15;
	localparam logic [6:0] ROUND_LAST = 7'd79;
	localparam logic [6:0] ROUND_W_EXP = 7'd16;
	localparam logic [6:0] ROUND_P2   = 7'd20;
	localparam logic [6:0] ROUND_P3   = 7'd40;
	localparam logic [6:0] ROUND_P4   = 7'd60;

	// SHA-1 round constants
	localparam logic [31:0] RK0 = 32'h5A827999;
	localparam logic [31:0] RK1 = 32'h6ED9EBA1;
	localparam logic [31:0] RK2 = 32'h8F1BBCDC;
	localparam logic [31:0] RK3 = 32'hCA62C1D6;

	// SHA-1 initial chaining values
	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	// Configuration register reset values
	localparam logic [63:0] LCG_MUL_RESET = 64'd6726226163547670885;
	localparam logic [63:0] LCG_INC_RESET = 64'd2531011;

	// Configuration register index, taken from paddr[3]
	localparam logic REG_LCG_MUL = 1'b0;
	localparam logic REG_LCG_INC = 1'b1;

	// Multiply step codes of the LCG sequence
	localparam logic [1:0] MSTEP_LL = 2'd0;
	localparam logic [1:0] MSTEP_LH = 2'd1;
	localparam logic [1:0] MSTEP_HL = 2'd2;
	localparam logic [1:0] MSTEP_END = 2'd3;

	// One queued message word, tagged with its place in the block
	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} word_entry_t;

	// Back end sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ROUND,
		ST_FINAL,
		ST_MUL,
		ST_EMIT
	} back_state_t;

	// Reverse the byte order of a 32-bit word
	function automatic logic [31:0] bswap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

`default_nettype wire

/* rtl/sha1_block_seed_derivation.sv */
// SHA-1 block seed derivation. Feed one padded 512-bit block as sixteen 32-bit
// message words, word 0 first; after the sixteenth word the block returns one
// result beat with pre_seed (byte-swapped H1 high, byte-swapped H0 low) and seed
// (pre_seed * lcg_multiplier + lcg_increment mod 2^64). Words 0 to 14 give no
// result. A word enters a four-entry queue; the back end pulls one word per cycle
// into its schedule window while it waits for a block, then works on the block:
// 80 rounds in one round unit (one round per cycle), forming the pre-seed, the
// LCG step on the shared 32x32 multiplier and the hand-off of the result. Only
// then does it take the next block, so the single round unit sets the rate. The
// front end keeps taking words into the queue while the rounds run, until the
// queue is full. lcg_multiplier sits at byte address 0 and lcg_increment at 8,
// both 64-bit; write them only while no block is in flight.
// Depends on sbsd_pkg, sbsd_front, sbsd_queue and sbsd_back.
`default_nettype none

module sha1_block_seed_derivation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Message word channel
	input  wire logic        word_valid,
	output logic             word_stall,
	input  wire logic [31:0] message_word,
	// Result channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [63:0]      pre_seed,
	output logic [63:0]      seed,
	// Configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	logic [63:0] lcg_mul_q;
	logic [63:0] lcg_inc_q;
	logic        cfg_write;

	logic                  q_full;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_valid;
	sbsd_pkg::word_entry_t push_entry;
	sbsd_pkg::word_entry_t head_entry;

	// Register file
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_mul_q <= sbsd_pkg::LCG_MUL_RESET;
			lcg_inc_q <= sbsd_pkg::LCG_INC_RESET;
		end else if (cfg_write) begin
			case (paddr[3])
				sbsd_pkg::REG_LCG_MUL: lcg_mul_q <= pwdata;
				sbsd_pkg::REG_LCG_INC: lcg_inc_q <= pwdata;
				default:               lcg_mul_q <= lcg_mul_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			sbsd_pkg::REG_LCG_MUL: prdata = lcg_mul_q;
			sbsd_pkg::REG_LCG_INC: prdata = lcg_inc_q;
			default:               prdata = '0;
		endcase
	end

	sbsd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.message_word (message_word),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (push_entry)
	);

	sbsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_entry (head_entry)
	);

	sbsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_entry      (head_entry),
		.q_pop        (q_pop),
		.lcg_mul      (lcg_mul_q),
		.lcg_inc      (lcg_inc_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pre_seed     (pre_seed),
		.seed         (seed)
	);

endmodule

`default_nettype wire

/* rtl/sbsd_front.sv */
// Front end: takes message words, counts them within the block and tags the last one.
// Depends on sbsd_pkg for the queue entry type and the word count limit.
`default_nettype none

module sbsd_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 word_valid,
	output logic                      word_stall,
	input  wire logic [31:0]          message_word,
	input  wire logic                 q_full,
	output logic                      q_push,
	output sbsd_pkg::word_entry_t     q_entry
);

	logic [3:0] count_q;

	// Stall while the queue has no room
	assign word_stall = q_full;
	assign q_push     = word_valid && !q_full;

	// Tag the sixteenth word of the block
	always_comb begin
		q_entry.word = message_word;
		q_entry.last = (count_q == sbsd_pkg::WORD_LAST);
	end

	// Advance the word count, wrapping after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_push) begin
			count_q <= count_q + 4'd1;
		end
	end

endmodule

`default_nettype wire

/* rtl/sbsd_queue.sv */
// Short FIFO of tagged message words between the front end and the back end.
// Depends on sbsd_pkg for the entry type and depth constants.
`default_nettype none

module sbsd_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire sbsd_pkg::word_entry_t push_entry,
	output logic                       full,
	input  wire logic                  pop,
	output logic                       head_valid,
	output sbsd_pkg::word_entry_t      head_entry
);

	sbsd_pkg::word_entry_t                 slot_q [sbsd_pkg::QUEUE_DEPTH];
	logic [sbsd_pkg::QUEUE_PTR_W-1:0]      wr_ptr_q;
	logic [sbsd_pkg::QUEUE_PTR_W-1:0]      rd_ptr_q;
	logic [sbsd_pkg::QUEUE_CNT_W-1:0]      count_q;
	logic                                  do_push;
	logic                                  do_pop;

	assign full       = (count_q == sbsd_pkg::QUEUE_CNT_W'(sbsd_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/sbsd_back.sv */
// Back end: loads the schedule window, runs the 80 SHA-1 rounds, forms the
// pre-seed, applies the LCG step with one shared 32x32 multiplier and holds the result.
// Depends on sbsd_pkg for constants, the queue entry type and the state type.
`default_nettype none

module sbsd_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire sbsd_pkg::word_entry_t q_entry,
	output logic                       q_pop,
	input  wire logic [63:0]           lcg_mul,
	input  wire logic [63:0]           lcg_inc,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic [63:0]                pre_seed,
	output logic [63:0]                seed
);

	sbsd_pkg::back_state_t state_q;
	sbsd_pkg::back_state_t state_d;

	logic [31:0] win_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  rnd_q;
	logic [1:0]  mstep_q;
	logic [63:0] pre_q;
	logic [63:0] acc_q;
	logic [63:0] prod_q;
	logic        ovalid_q;
	logic [63:0] pre_seed_q;
	logic [63:0] seed_q;

	logic        load_word;
	logic        emit;
	logic        out_free;
	logic [31:0] wt;
	logic [31:0] w_mix;
	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] tmp;
	logic [31:0] mop_a;
	logic [31:0] mop_b;
	logic [63:0] prod_d;

	assign out_free = !ovalid_q || !result_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sbsd_pkg::ST_LOAD: begin
				if (q_valid && q_entry.last) begin
					state_d = sbsd_pkg::ST_ROUND;
				end
			end
			sbsd_pkg::ST_ROUND: begin
				if (rnd_q == sbsd_pkg::ROUND_LAST) begin
					state_d = sbsd_pkg::ST_FINAL;
				end
			end
			sbsd_pkg::ST_FINAL: state_d = sbsd_pkg::ST_MUL;
			sbsd_pkg::ST_MUL: begin
				if (mstep_q == sbsd_pkg::MSTEP_END) begin
					state_d = sbsd_pkg::ST_EMIT;
				end
			end
			sbsd_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = sbsd_pkg::ST_LOAD;
				end
			end
			default: state_d = sbsd_pkg::ST_LOAD;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		load_word = 1'b0;
		emit      = 1'b0;
		case (state_q)
			sbsd_pkg::ST_LOAD: load_word = q_valid;
			sbsd_pkg::ST_EMIT: emit      = out_free;
			default: begin
				load_word = 1'b0;
				emit      = 1'b0;
			end
		endcase
	end

	assign q_pop = load_word;

	// Schedule word and round function
	always_comb begin
		w_mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
		wt    = (rnd_q < sbsd_pkg::ROUND_W_EXP) ? win_q[0] : {w_mix[30:0], w_mix[31]};
		if (rnd_q < sbsd_pkg::ROUND_P2) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sbsd_pkg::RK0;
		end else if (rnd_q < sbsd_pkg::ROUND_P3) begin
			f = b_q ^ c_q ^ d_q;
			k = sbsd_pkg::RK1;
		end else if (rnd_q < sbsd_pkg::ROUND_P4) begin
			f = (b_q & c_q) | ((b_q | c_q) & d_q);
			k = sbsd_pkg::RK2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sbsd_pkg::RK3;
		end
		tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;
	end

	// Select operands of the shared multiplier
	always_comb begin
		case (mstep_q)
			sbsd_pkg::MSTEP_LL: begin
				mop_a = pre_q[31:0];
				mop_b = lcg_mul[31:0];
			end
			sbsd_pkg::MSTEP_LH: begin
				mop_a = pre_q[31:0];
				mop_b = lcg_mul[63:32];
			end
			sbsd_pkg::MSTEP_HL: begin
				mop_a = pre_q[63:32];
				mop_b = lcg_mul[31:0];
			end
			default: begin
				mop_a = '0;
				mop_b = '0;
			end
		endcase
		prod_d = {32'h0, mop_a} * {32'h0, mop_b};
	end

	// Shift the schedule window: load words, then recirculate and expand
	always_ff @(posedge clk) begin
		if (load_word || state_q == sbsd_pkg::ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= load_word ? q_entry.word : wt;
		end
	end

	// Working variables, pre-seed and LCG datapath
	always_ff @(posedge clk) begin
		case (state_q)
			sbsd_pkg::ST_LOAD: begin
				a_q <= sbsd_pkg::IV0;
				b_q <= sbsd_pkg::IV1;
				c_q <= sbsd_pkg::IV2;
				d_q <= sbsd_pkg::IV3;
				e_q <= sbsd_pkg::IV4;
			end
			sbsd_pkg::ST_ROUND: begin
				e_q <= d_q;
				d_q <= c_q;
				c_q <= {b_q[1:0], b_q[31:2]};
				b_q <= a_q;
				a_q <= tmp;
			end
			sbsd_pkg::ST_FINAL: begin
				pre_q <= {sbsd_pkg::bswap32(sbsd_pkg::IV1 + b_q),
					sbsd_pkg::bswap32(sbsd_pkg::IV0 + a_q)};
				acc_q <= lcg_inc;
			end
			sbsd_pkg::ST_MUL: begin
				prod_q <= prod_d;
				case (mstep_q)
					sbsd_pkg::MSTEP_LH:  acc_q <= acc_q + prod_q;
					sbsd_pkg::MSTEP_HL:  acc_q <= acc_q + {prod_q[31:0], 32'h0};
					sbsd_pkg::MSTEP_END: acc_q <= acc_q + {prod_q[31:0], 32'h0};
					default:             acc_q <= acc_q;
				endcase
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// Hold the result until the consumer takes it
	always_ff @(posedge clk) begin
		if (emit) begin
			pre_seed_q <= pre_q;
			seed_q     <= acc_q;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sbsd_pkg::ST_LOAD;
			rnd_q    <= '0;
			mstep_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sbsd_pkg::ST_ROUND) begin
				rnd_q <= rnd_q + 7'd1;
			end else begin
				rnd_q <= '0;
			end
			if (state_q == sbsd_pkg::ST_MUL) begin
				mstep_q <= mstep_q + 2'd1;
			end else begin
				mstep_q <= '0;
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (!result_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign result_valid = ovalid_q;
	assign pre_seed     = pre_seed_q;
	assign seed         = seed_q;

endmodule

`default_nettype wire

/* rtl/sbsd_checker.sv */
// Port-level checker for the seed derivation block, bound to the top level.
// Depends on sbsd_pkg for the configuration reset values, register indexes and word count limit.
`default_nettype none

module sbsd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        word_valid,
	input wire logic        word_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [63:0] pre_seed,
	input wire logic [63:0] seed,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [3:0]  paddr,
	input wire logic [63:0] pwdata,
	input wire logic        pready
);

	logic [63:0] mul_q;
	logic [63:0] inc_q;
	logic [3:0]  words_q;
	logic [3:0]  owed_q;
	logic        word_beat;
	logic        result_beat;
	logic        block_done;

	assign word_beat   = word_valid && !word_stall;
	assign result_beat = result_valid && !result_stall;
	assign block_done  = word_beat && (words_q == sbsd_pkg::WORD_LAST);

	// Shadow the configuration registers from the port writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q <= sbsd_pkg::LCG_MUL_RESET;
			inc_q <= sbsd_pkg::LCG_INC_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[3] == sbsd_pkg::REG_LCG_INC) begin
				inc_q <= pwdata;
			end else begin
				mul_q <= pwdata;
			end
		end
	end

	// Count words within a block and results still owed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= '0;
			owed_q  <= '0;
		end else begin
			if (word_beat) begin
				words_q <= words_q + 4'd1;
			end
			case ({block_done, result_beat})
				2'b10:   owed_q <= owed_q + 4'd1;
				2'b01:   owed_q <= owed_q - 4'd1;
				default: owed_q <= owed_q;
			endcase
		end
	end

	// A stalled result beat stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result_valid dropped while stalled");

	// A stalled result beat keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(pre_seed) && $stable(seed))
		else $error("result payload changed while stalled");

	// Seed is the pre-seed advanced by one LCG step
	a_seed_lcg: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> seed == (pre_seed * mul_q + inc_q))
		else $error("seed does not match one LCG step of pre_seed");

	// Results appear only for completed blocks
	a_result_owed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> owed_q != 4'd0)
		else $error("result offered with no completed block");

endmodule

bind sha1_block_seed_derivation sbsd_checker u_sbsd_checker (.*);

`default_nettype wire

/* tb/sv/sha1_block_seed_derivation_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for sha1_block_seed_derivation: streams message blocks one word per beat,
// rewrites the LCG registers between phases and checks every pre_seed/seed result beat.
// Needs only the block under test; the expected values come from a SHA-1 predictor held here.

module sha1_block_seed_derivation_test;

	// SHA-1 round constants and initial chaining values
	localparam bit [31:0] K_ROUNDS_0_19  = 32'h5A827999;
	localparam bit [31:0] K_ROUNDS_20_39 = 32'h6ED9EBA1;
	localparam bit [31:0] K_ROUNDS_40_59 = 32'h8F1BBCDC;
	localparam bit [31:0] K_ROUNDS_60_79 = 32'hCA62C1D6;
	localparam bit [31:0] H0_INIT = 32'h67452301;
	localparam bit [31:0] H1_INIT = 32'hEFCDAB89;
	localparam bit [31:0] H2_INIT = 32'h98BADCFE;
	localparam bit [31:0] H3_INIT = 32'h10325476;
	localparam bit [31:0] H4_INIT = 32'hC3D2E1F0;

	// LCG register map and reset values
	localparam bit [3:0]  ADDR_MULTIPLIER = 4'd0;
	localparam bit [3:0]  ADDR_INCREMENT  = 4'd8;
	localparam bit [63:0] MULTIPLIER_AT_RESET = 64'd6726226163547670885;
	localparam bit [63:0] INCREMENT_AT_RESET  = 64'd2531011;

	// Run length
	localparam int RANDOM_WORDS  = 1330;
	localparam int SETTLE_CYCLES = 160;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct {
		bit [63:0] pre_seed;
		bit [63:0] seed;
	} seed_pair_t;

	// Predicts pre_seed/seed per block and checks result beats in order
	class seed_checker;
		bit [31:0]  window [16];
		bit [3:0]   word_index;
		bit [63:0]  multiplier;
		bit [63:0]  increment;
		seed_pair_t pending_seeds [$];
		int         mismatches;

		function new();
			word_index = '0;
			multiplier = MULTIPLIER_AT_RESET;
			increment  = INCREMENT_AT_RESET;
			mismatches = 0;
		endfunction

		function bit [31:0] flip_bytes(bit [31:0] x);
			return {x[7:0], x[15:8], x[23:16], x[31:24]};
		endfunction

		// Run the 80 rounds over the stored block from the standard chaining values
		function bit [63:0] derive_pre_seed();
			bit [31:0] w [16];
			bit [31:0] a, b, c, d, e, f, k, wt, sum;
			w = window;
			a = H0_INIT;
			b = H1_INIT;
			c = H2_INIT;
			d = H3_INIT;
			e = H4_INIT;
			for (int t = 0; t < 80; t++) begin
				if (t < 16) begin
					wt = w[t];
				end else begin
					wt = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
					wt = {wt[30:0], wt[31]};
					w[t % 16] = wt;
				end
				if (t < 20) begin
					f = (b & c) | (~b & d);
					k = K_ROUNDS_0_19;
				end else if (t < 40) begin
					f = b ^ c ^ d;
					k = K_ROUNDS_20_39;
				end else if (t < 60) begin
					f = (b & c) | ((b | c) & d);
					k = K_ROUNDS_40_59;
				end else begin
					f = b ^ c ^ d;
					k = K_ROUNDS_60_79;
				end
				sum = {a[26:0], a[31:27]} + f + e + k + wt;
				e = d;
				d = c;
				c = {b[1:0], b[31:2]};
				b = a;
				a = sum;
			end
			return {flip_bytes(H1_INIT + b), flip_bytes(H0_INIT + a)};
		endfunction

		// Store an accepted word; the sixteenth one closes the block
		function void note_word(bit [31:0] word);
			seed_pair_t next_pair;
			window[word_index] = word;
			if (word_index == 4'd15) begin
				next_pair.pre_seed = derive_pre_seed();
				next_pair.seed = next_pair.pre_seed * multiplier + increment;
				pending_seeds.push_back(next_pair);
			end
			word_index = word_index + 4'd1;
		endfunction

		function void check_result(logic [63:0] got_pre_seed, logic [63:0] got_seed);
			seed_pair_t want;
			if (pending_seeds.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, got pre_seed %h seed %h",
					$time, got_pre_seed, got_seed);
				mismatches++;
				return;
			end
			want = pending_seeds.pop_front();
			if (got_pre_seed !== want.pre_seed) begin
				$display("%0t: pre_seed mismatch: expected %h, got %h",
					$time, want.pre_seed, got_pre_seed);
				mismatches++;
			end
			if (got_seed !== want.seed) begin
				$display("%0t: seed mismatch: expected %h, got %h", $time, want.seed, got_seed);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        word_valid = 1'b0;
	logic        word_stall;
	logic [31:0] message_word = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [63:0] pre_seed;
	logic [63:0] seed;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	seed_checker seed_ledger;
	int          cycle_count = 0;
	int          stall_hold = 0;
	int          stall_style = 0;

	// Opening block of field extremes, then half of a second block
	bit [31:0] opening_words [24] = '{
		32'hFFFFFFFF, 32'h00000000, 32'hAAAAAAAA, 32'h55555555,
		32'h80000000, 32'h00000001, 32'h7FFFFFFF, 32'hFFFFFFFE,
		32'h0F0F0F0F, 32'hF0F0F0F0, 32'h01234567, 32'h89ABCDEF,
		32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000018,
		32'h61626380, 32'h00000000, 32'h00000000, 32'hFFFFFFFF,
		32'h00000000, 32'h12345678, 32'h80000000, 32'hFFFFFFFF
	};

	sha1_block_seed_derivation i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.message_word (message_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pre_seed     (pre_seed),
		.seed         (seed),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Check result beats and record accepted word beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				seed_ledger.check_result(pre_seed, seed);
			if (word_valid && !word_stall)
				seed_ledger.note_word(message_word);
		end
	end

	// Stall the result channel: free-flowing, random, sparse or solid stretches
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_hold = $urandom_range(1, 30);
			stall_style = $urandom_range(0, 3);
		end else begin
			stall_hold--;
		end
		case (stall_style)
			0: result_stall <= 1'b0;
			1: result_stall <= $urandom_range(0, 1);
			2: result_stall <= ($urandom_range(0, 3) == 0);
			default: result_stall <= 1'b1;
		endcase
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results pending", $time,
				seed_ledger.pending_seeds.size());
			$display("sha1_block_seed_derivation_test: errors");
			$finish;
		end
	end

	// Present one word and hold it until the beat is taken
	task automatic send_word(input bit [31:0] word);
		word_valid <= 1'b1;
		message_word <= word;
		@(posedge clk);
		while (word_stall)
			@(posedge clk);
	endtask

	function automatic bit [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'd1 << $urandom_range(0, 31);
			3: return ~(32'd1 << $urandom_range(0, 31));
			default: return $urandom();
		endcase
	endfunction

	function automatic bit [63:0] pick_lcg_value();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 64'd1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// Send random words in bursts of random length with random gaps
	task automatic run_phase(input int word_total);
		int left;
		int burst;
		left = word_total;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && left > 0) begin
				send_word(pick_word());
				burst--;
				left--;
			end
			if ($urandom_range(0, 3) != 0) begin
				word_valid <= 1'b0;
				repeat ($urandom_range(1, 12))
					@(posedge clk);
			end
		end
		word_valid <= 1'b0;
	endtask

	// Hold off until every expected result is in, then let the back end settle
	task automatic drain();
		while (seed_ledger.pending_seeds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the access edge
	task automatic write_lcg_register(input bit [3:0] addr, input bit [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_MULTIPLIER)
			seed_ledger.multiplier = value;
		else
			seed_ledger.increment = value;
	endtask

	initial begin
		int words_sent;
		int phase;
		seed_ledger = new();
		words_sent = 0;
		phase = 0;

		// Hold reset, then release it
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: one full block at reset settings, then half a block
		foreach (opening_words[i])
			send_word(opening_words[i]);
		word_valid <= 1'b0;
		drain();

		// Change both registers mid-block; the random phase completes that block
		write_lcg_register(ADDR_MULTIPLIER, '1);
		write_lcg_register(ADDR_INCREMENT, '0);

		while (words_sent < RANDOM_WORDS) begin
			int word_total;
			word_total = $urandom_range(40, 200);
			if (word_total > RANDOM_WORDS - words_sent)
				word_total = RANDOM_WORDS - words_sent;
			run_phase(word_total);
			words_sent += word_total;
			drain();
			case (phase)
				0: begin
					write_lcg_register(ADDR_MULTIPLIER, '0);
					write_lcg_register(ADDR_INCREMENT, '1);
				end
				1: begin
					write_lcg_register(ADDR_MULTIPLIER, 64'd1);
					write_lcg_register(ADDR_INCREMENT, 64'd0);
				end
				2: begin
					write_lcg_register(ADDR_MULTIPLIER, '1);
					write_lcg_register(ADDR_INCREMENT, '1);
				end
				3: begin
					write_lcg_register(ADDR_MULTIPLIER, MULTIPLIER_AT_RESET);
					write_lcg_register(ADDR_INCREMENT, INCREMENT_AT_RESET);
				end
				default: begin
					if ($urandom_range(0, 3) != 0)
						write_lcg_register(ADDR_MULTIPLIER, pick_lcg_value());
					if ($urandom_range(0, 3) != 0)
						write_lcg_register(ADDR_INCREMENT, pick_lcg_value());
				end
			endcase
			phase++;
		end

		// Flush the partial block so the last settings also reach a result
		while (seed_ledger.word_index != 4'd0)
			send_word(pick_word());
		word_valid <= 1'b0;
		drain();

		if (seed_ledger.mismatches == 0 && seed_ledger.pending_seeds.size() == 0) begin
			$display("sha1_block_seed_derivation_test: clean");
		end else begin
			$display("sha1_block_seed_derivation_test: errors");
		end
		$finish;
	end

endmodule
